>>> design/line_line_intersection_macros.svh
// ----------------------------------------------------------------------------
// line_line_intersection_macros
// assertion macros shared by the intersection design
// ----------------------------------------------------------------------------
`ifndef LINE_LINE_INTERSECTION_MACROS_SVH
`define LINE_LINE_INTERSECTION_MACROS_SVH

// same-cycle implication, disabled during reset
`define LLI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lli_pkg.sv
// ----------------------------------------------------------------------------
// lli_pkg
// shared constants and types of the line intersection pipeline
// ----------------------------------------------------------------------------
package lli_pkg;

    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    // side data that rides along with a division
    typedef struct packed {
        logic parallel;
        logic neg;
    } div_tag_t;

endpackage

>>> design/lli_if.sv
// ----------------------------------------------------------------------------
// lli_if
// valid/ready channels for query words and answer words
// ----------------------------------------------------------------------------
interface lli_query_if;
    logic                          valid;
    logic                          ready;
    logic [lli_pkg::FIELD_W-1:0]   first_start_x;
    logic [lli_pkg::FIELD_W-1:0]   first_start_y;
    logic [lli_pkg::FIELD_W-1:0]   first_end_x;
    logic [lli_pkg::FIELD_W-1:0]   first_end_y;
    logic [lli_pkg::FIELD_W-1:0]   second_start_x;
    logic [lli_pkg::FIELD_W-1:0]   second_start_y;
    logic [lli_pkg::FIELD_W-1:0]   second_end_x;
    logic [lli_pkg::FIELD_W-1:0]   second_end_y;

    modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                    second_start_x, second_start_y, second_end_x, second_end_y,
                    input ready);
    modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  output ready);
endinterface

interface lli_answer_if;
    logic                          valid;
    logic                          ready;
    logic [lli_pkg::FIELD_W-1:0]   cross_x;
    logic [lli_pkg::FIELD_W-1:0]   cross_y;
    logic [1:0]                    status;

    modport source (output valid, cross_x, cross_y, status, input ready);
    modport sink (input valid, cross_x, cross_y, status, output ready);
endinterface

>>> design/lli_div.sv
// ----------------------------------------------------------------------------
// lli_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module lli_div #(
    parameter int NUM_W = 53,
    parameter int DIV_W = 35,
    parameter int TAG_W = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    input  logic [TAG_W-1:0] tag,
    output logic             out_valid,
    output logic [NUM_W-1:0] quo,
    output logic [TAG_W-1:0] out_tag
);

    logic [NUM_W-1:0] valid_reg;
    logic [DIV_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DIV_W-1:0] den_reg [NUM_W];
    logic [TAG_W-1:0] tag_reg [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic             v_in;
        logic [DIV_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DIV_W-1:0] den_in;
        logic [TAG_W-1:0] tag_in;
        logic [DIV_W:0]   trial;
        logic [DIV_W:0]   diff;
        logic             ge;
        logic [DIV_W-1:0] rem_next;
        logic [NUM_W-1:0] nq_next;

        if (s == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
            assign tag_in = tag;
        end
        else begin : g_rest
            assign v_in   = valid_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign nq_in  = nq_reg[s-1];
            assign den_in = den_reg[s-1];
            assign tag_in = tag_reg[s-1];
        end

        // shift in the next numerator bit, subtract if it fits
        assign trial    = {rem_in, nq_in[NUM_W-1]};
        assign ge       = trial >= {1'b0, den_in};
        assign diff     = trial - {1'b0, den_in};
        assign rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        assign nq_next  = {nq_in[NUM_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                nq_reg[s]  <= nq_next;
                den_reg[s] <= den_in;
                tag_reg[s] <= tag_in;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign quo       = nq_reg[NUM_W-1];
    assign out_tag   = tag_reg[NUM_W-1];

endmodule

>>> design/line_line_intersection.sv
// ----------------------------------------------------------------------------
// line_line_intersection
// exact integer crossing point of two infinite lines
// ----------------------------------------------------------------------------
// Takes one query word per cycle while the pipeline advances (two lines, each
// as a start and end point) and returns one answer word per query, in order:
// the crossing point with both quotients truncated toward zero, and a status
// (ok, parallel, beyond 32-bit signed, outside 0 .. 2^COORD_BITS-1; cross
// fields are zero unless ok). Throughput is one word per cycle while not
// stalled. The pipeline has six arithmetic stages, then one restoring divider
// stage per numerator bit (3*COORD_BITS+5 of them), then the answer register.
// The whole pipeline advances whenever the answer register is empty or
// being taken, so a stall freezes every stage in place.
// ----------------------------------------------------------------------------
module line_line_intersection #(
    parameter int COORD_BITS = lli_pkg::COORD_BITS
) (
    input logic         clk,
    input logic         rst_n,
    lli_query_if.sink   query,
    lli_answer_if.source answer
);

    `include "line_line_intersection_macros.svh"

    localparam int W      = COORD_BITS;
    localparam int P2_W   = 2 * W + 2;       // product of two deltas
    localparam int P3_W   = 3 * W + 3;       // product of three terms
    localparam int NUM_W  = 3 * W + 5;       // numerator, signed and magnitude
    localparam int DIV_W  = 2 * W + 3;       // divisor, signed and magnitude
    localparam int QX_W   = (NUM_W > 33) ? NUM_W : 33;
    localparam int TAG_W  = $bits(lli_pkg::div_tag_t);

    // pipeline advance: answer slot free or being drained
    logic en;
    logic out_valid_reg;
    assign en          = !out_valid_reg || answer.ready;
    assign query.ready = en;

    // stage 1: coordinates, low COORD_BITS only
    logic             v1_reg;
    logic [W-1:0]     xa1_reg, ya1_reg, xa1e_reg, ya1e_reg;
    logic [W-1:0]     xb1_reg, yb1_reg, xb1e_reg, yb1e_reg;

    // stage 2: deltas
    logic                v2_reg;
    logic signed [W:0]   dxa2_reg, dya2_reg, dxb2_reg, dyb2_reg;
    logic signed [W:0]   dyab2_reg, dxab2_reg;   // yb-ya, xb-xa
    logic signed [W:0]   xa2_reg, ya2_reg, xb2_reg, yb2_reg;

    // stage 3: products of two
    logic                  v3_reg;
    logic signed [P2_W-1:0] pxx3_reg, pba3_reg, pab3_reg, pyy3_reg;
    logic signed [W:0]      dyab3_reg, dxab3_reg;
    logic signed [W:0]      xa3_reg, ya3_reg, xb3_reg, yb3_reg;

    // stage 4: divisor and products of three
    logic                   v4_reg;
    logic signed [DIV_W-1:0] d4_reg;
    logic signed [P3_W-1:0]  tx1_4_reg, tx2_4_reg, tx3_4_reg;
    logic signed [P3_W-1:0]  ty1_4_reg, ty2_4_reg, ty3_4_reg;

    // stage 5: numerators
    logic                   v5_reg;
    logic signed [DIV_W-1:0] d5_reg;
    logic signed [NUM_W-1:0] nx5_reg, ny5_reg;

    // stage 6: magnitudes and signs into the dividers
    logic                v6_reg;
    logic [NUM_W-1:0]    mx6_reg, my6_reg;
    logic [DIV_W-1:0]    md6_reg;
    lli_pkg::div_tag_t   tx6_reg, ty6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= query.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            xa1_reg  <= W'(query.first_start_x);
            ya1_reg  <= W'(query.first_start_y);
            xa1e_reg <= W'(query.first_end_x);
            ya1e_reg <= W'(query.first_end_y);
            xb1_reg  <= W'(query.second_start_x);
            yb1_reg  <= W'(query.second_start_y);
            xb1e_reg <= W'(query.second_end_x);
            yb1e_reg <= W'(query.second_end_y);

            // stage 2
            dxa2_reg  <= $signed({1'b0, xa1e_reg}) - $signed({1'b0, xa1_reg});
            dya2_reg  <= $signed({1'b0, ya1e_reg}) - $signed({1'b0, ya1_reg});
            dxb2_reg  <= $signed({1'b0, xb1e_reg}) - $signed({1'b0, xb1_reg});
            dyb2_reg  <= $signed({1'b0, yb1e_reg}) - $signed({1'b0, yb1_reg});
            dyab2_reg <= $signed({1'b0, yb1_reg}) - $signed({1'b0, ya1_reg});
            dxab2_reg <= $signed({1'b0, xb1_reg}) - $signed({1'b0, xa1_reg});
            xa2_reg   <= $signed({1'b0, xa1_reg});
            ya2_reg   <= $signed({1'b0, ya1_reg});
            xb2_reg   <= $signed({1'b0, xb1_reg});
            yb2_reg   <= $signed({1'b0, yb1_reg});

            // stage 3
            pxx3_reg  <= dxa2_reg * dxb2_reg;
            pba3_reg  <= dxb2_reg * dya2_reg;
            pab3_reg  <= dxa2_reg * dyb2_reg;
            pyy3_reg  <= dya2_reg * dyb2_reg;
            dyab3_reg <= dyab2_reg;
            dxab3_reg <= dxab2_reg;
            xa3_reg   <= xa2_reg;
            ya3_reg   <= ya2_reg;
            xb3_reg   <= xb2_reg;
            yb3_reg   <= yb2_reg;

            // stage 4: divisor for x; y uses its negation
            d4_reg    <= DIV_W'(pba3_reg) - DIV_W'(pab3_reg);
            tx1_4_reg <= pxx3_reg * dyab3_reg;
            tx2_4_reg <= pba3_reg * xa3_reg;
            tx3_4_reg <= pab3_reg * xb3_reg;
            ty1_4_reg <= pyy3_reg * dxab3_reg;
            ty2_4_reg <= pab3_reg * ya3_reg;
            ty3_4_reg <= pba3_reg * yb3_reg;

            // stage 5
            d5_reg  <= d4_reg;
            nx5_reg <= NUM_W'(tx1_4_reg) + NUM_W'(tx2_4_reg) - NUM_W'(tx3_4_reg);
            ny5_reg <= NUM_W'(ty1_4_reg) + NUM_W'(ty2_4_reg) - NUM_W'(ty3_4_reg);

            // stage 6
            mx6_reg <= nx5_reg[NUM_W-1] ? NUM_W'(-nx5_reg) : NUM_W'(nx5_reg);
            my6_reg <= ny5_reg[NUM_W-1] ? NUM_W'(-ny5_reg) : NUM_W'(ny5_reg);
            md6_reg <= d5_reg[DIV_W-1] ? DIV_W'(-d5_reg) : DIV_W'(d5_reg);
            tx6_reg.parallel <= (d5_reg == '0);
            tx6_reg.neg      <= nx5_reg[NUM_W-1] != d5_reg[DIV_W-1];
            ty6_reg.parallel <= (d5_reg == '0);
            ty6_reg.neg      <= ny5_reg[NUM_W-1] == d5_reg[DIV_W-1];
        end
    end

    // dividers
    logic              qxv, qyv;
    logic [NUM_W-1:0]  qx, qy;
    logic [TAG_W-1:0]  qx_tag_bits, qy_tag_bits;
    lli_pkg::div_tag_t qx_tag, qy_tag;

    lli_div #(.NUM_W(NUM_W), .DIV_W(DIV_W), .TAG_W(TAG_W)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .num       (mx6_reg),
        .den       (md6_reg),
        .tag       (TAG_W'(tx6_reg)),
        .out_valid (qxv),
        .quo       (qx),
        .out_tag   (qx_tag_bits)
    );

    lli_div #(.NUM_W(NUM_W), .DIV_W(DIV_W), .TAG_W(TAG_W)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .num       (my6_reg),
        .den       (md6_reg),
        .tag       (TAG_W'(ty6_reg)),
        .out_valid (qyv),
        .quo       (qy),
        .out_tag   (qy_tag_bits)
    );

    assign qx_tag = lli_pkg::div_tag_t'(qx_tag_bits);
    assign qy_tag = lli_pkg::div_tag_t'(qy_tag_bits);

    // final classification
    logic [QX_W-1:0]   qxe, qye;
    logic              negx, negy, ovx, ovy, rangex, rangey;
    lli_pkg::status_t  status_next;

    assign qxe  = QX_W'(qx);
    assign qye  = QX_W'(qy);
    // negative only when the quotient is nonzero
    assign negx = qx_tag.neg && (qx != '0);
    assign negy = qy_tag.neg && (qy != '0);
    assign ovx  = negx ? (qxe > QX_W'(64'h8000_0000)) : (qxe > QX_W'(64'h7fff_ffff));
    assign ovy  = negy ? (qye > QX_W'(64'h8000_0000)) : (qye > QX_W'(64'h7fff_ffff));
    assign rangex = negx || (qxe > QX_W'((64'd1 << W) - 64'd1));
    assign rangey = negy || (qye > QX_W'((64'd1 << W) - 64'd1));

    always_comb
    begin
        if (qx_tag.parallel)
        begin
            status_next = lli_pkg::ST_PARALLEL;
        end
        else if (ovx || ovy)
        begin
            status_next = lli_pkg::ST_OVERFLOW;
        end
        else if (rangex || rangey)
        begin
            status_next = lli_pkg::ST_RANGE;
        end
        else
        begin
            status_next = lli_pkg::ST_OK;
        end
    end

    // answer register
    logic [lli_pkg::FIELD_W-1:0] cross_x_reg, cross_y_reg;
    lli_pkg::status_t            status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= qxv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg  <= status_next;
            cross_x_reg <= (status_next == lli_pkg::ST_OK) ? lli_pkg::FIELD_W'(qx) : '0;
            cross_y_reg <= (status_next == lli_pkg::ST_OK) ? lli_pkg::FIELD_W'(qy) : '0;
        end
    end

    assign answer.valid   = out_valid_reg;
    assign answer.cross_x = cross_x_reg;
    assign answer.cross_y = cross_y_reg;
    assign answer.status  = status_reg;

    // both dividers stay in lockstep
    `LLI_ASSERT_NOW(a_div_lockstep, 1'b1, qxv == qyv, "x and y dividers out of step")
    // a failed word never carries a point
    `LLI_ASSERT_NOW(a_fail_zero, out_valid_reg && (status_reg != lli_pkg::ST_OK),
        (cross_x_reg == '0) && (cross_y_reg == '0), "failed word carries a point")
    // a stall freezes the divider feed
    `LLI_ASSERT_NEXT(a_stall_hold, !en, $stable(v6_reg) && $stable(qxv),
        "pipeline moved during a stall")

endmodule
